>>> sv/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants for the MAC learning table: operation codes,
// field widths, the query word, the chain carry word and the commit command.
// ----------------------------------------------------------------------------
`default_nettype none

package mlt_pkg;

    localparam int MAC_W  = 48;
    localparam int VLAN_W = 12;
    localparam int PORT_W = 6;
    localparam int FUNC_W = 2;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int PORT_COUNT_DEF    = 24;

    localparam logic [FUNC_W-1:0] FUNC_LEARN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    // Operation word broadcast to every cell.
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [VLAN_W-1:0] vlan;
        logic [PORT_W-1:0] port;
        logic              mk_static;
    } t_query;

    // Search status handed from one cell to the next.
    typedef struct packed {
        logic              found;
        logic [VLAN_W-1:0] vlan;
        logic [PORT_W-1:0] port;
        logic              is_static;
        logic              free_seen;
    } t_carry;

    // Table update issued to all cells in the commit cycle.
    typedef struct packed {
        logic upd;
        logic ins;
        logic del;
    } t_cmd;

endpackage

`default_nettype wire

>>> sv/mlt_cell.sv
// ----------------------------------------------------------------------------
// mlt_cell
// One table entry. Compares its MAC against the broadcast query, folds its
// status into the carry from the previous cell and registers the result for
// the next cell. Applies insert, update or delete when the commit says so.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mlt_pkg::t_query i_query,
    input  wire mlt_pkg::t_cmd  i_cmd,
    input  wire mlt_pkg::t_carry i_carry,
    output mlt_pkg::t_carry     o_carry
);

    logic                       r_valid;
    logic [mlt_pkg::MAC_W-1:0]  r_mac;
    logic [mlt_pkg::VLAN_W-1:0] r_vlan;
    logic [mlt_pkg::PORT_W-1:0] r_port;
    logic                       r_static;
    mlt_pkg::t_carry            r_carry;

    logic                       n_valid;
    logic [mlt_pkg::MAC_W-1:0]  n_mac;
    logic [mlt_pkg::VLAN_W-1:0] n_vlan;
    logic [mlt_pkg::PORT_W-1:0] n_port;
    logic                       n_static;
    mlt_pkg::t_carry            n_carry;

    logic w_match;
    logic w_first_free;

    assign w_match      = r_valid && (r_mac == i_query.mac);
    // Only the lowest free cell sees no free cell ahead of it.
    assign w_first_free = !r_valid && !i_carry.free_seen;

    always_comb begin
        n_carry.found     = i_carry.found | w_match;
        n_carry.vlan      = w_match ? r_vlan : i_carry.vlan;
        n_carry.port      = w_match ? r_port : i_carry.port;
        n_carry.is_static = w_match ? r_static : i_carry.is_static;
        n_carry.free_seen = i_carry.free_seen | !r_valid;
    end

    always_comb begin
        n_valid  = r_valid;
        n_mac    = r_mac;
        n_vlan   = r_vlan;
        n_port   = r_port;
        n_static = r_static;
        if (i_cmd.upd && w_match) begin
            n_vlan   = i_query.vlan;
            n_port   = i_query.port;
            n_static = i_query.mk_static;
        end
        if (i_cmd.ins && w_first_free) begin
            n_valid  = 1'b1;
            n_mac    = i_query.mac;
            n_vlan   = i_query.vlan;
            n_port   = i_query.port;
            n_static = i_query.mk_static;
        end
        if (i_cmd.del && w_match) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mac    <= n_mac;
        r_vlan   <= n_vlan;
        r_port   <= n_port;
        r_static <= n_static;
        r_carry  <= n_carry;
    end

    assign o_carry = r_carry;

endmodule

`default_nettype wire

>>> sv/mac_learning_table.sv
// ----------------------------------------------------------------------------
// mac_learning_table
// Switch MAC address table keyed by MAC alone, built as a row of entry cells.
// A query is broadcast to all cells, the search status ripples down the row
// one cell per cycle, and a commit then updates the table.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+---------------------------------
//   input    | i_in_valid  | o_in_stall   | func, mac_addr, vlan_id, port_num,
//            |             |              | make_static
//   output   | o_out_valid | i_out_stall  | hit, out_port, removed, table_full
//
// Each word passes through the capture of the query, the ripple of the search
// status through the cell row, and the commit. One word is in work at a
// time.
// The commit waits while a previous result is still stalled in the output
// register. Reset empties the table at once through the cell valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_learning_table #(
    parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF,
    parameter int PORT_COUNT    = mlt_pkg::PORT_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [mlt_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [mlt_pkg::MAC_W-1:0]   i_mac_addr,
    input  wire logic [mlt_pkg::VLAN_W-1:0]  i_vlan_id,
    input  wire logic [mlt_pkg::PORT_W-1:0]  i_port_num,
    input  wire logic                        i_make_static,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_hit,
    output logic [mlt_pkg::PORT_W-1:0]       o_out_port,
    output logic                             o_removed,
    output logic                             o_table_full
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              n_cnt;
    logic [mlt_pkg::FUNC_W-1:0]    r_func;
    mlt_pkg::t_query               r_query;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          r_hit;
    logic [mlt_pkg::PORT_W-1:0]    r_out_port;
    logic                          r_removed;
    logic                          r_table_full;

    logic            w_accept;
    logic            w_out_free;
    logic            w_commit;
    logic            w_learn_ok;
    logic            w_hit;
    mlt_pkg::t_cmd   w_cmd;
    mlt_pkg::t_carry w_chain [0:TABLE_ENTRIES];
    mlt_pkg::t_carry w_last;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_commit   = (r_state == ST_COMMIT) && w_out_free;

    assign w_chain[0] = '0;
    assign w_last     = w_chain[TABLE_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            mlt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_query (r_query),
                .i_cmd   (w_cmd),
                .i_carry (w_chain[g]),
                .o_carry (w_chain[g+1])
            );
        end
    endgenerate

    // The broadcast address is never stored, and a port beyond the switch is
    // ignored, so such a learn has no effect at all.
    assign w_learn_ok = (r_func == mlt_pkg::FUNC_LEARN)
                     && (r_query.mac != mlt_pkg::MAC_BCAST)
                     && ({1'b0, r_query.port} < 7'(PORT_COUNT));

    assign w_cmd.upd = w_commit && w_learn_ok && w_last.found && !w_last.is_static;
    assign w_cmd.ins = w_commit && w_learn_ok && !w_last.found && w_last.free_seen;
    assign w_cmd.del = w_commit && (r_func == mlt_pkg::FUNC_REMOVE)
                     && w_last.found && w_last.is_static;

    assign w_hit = (r_func == mlt_pkg::FUNC_LOOKUP) && w_last.found
                && (w_last.vlan == r_query.vlan);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SEARCH;
                    n_cnt   = '0;
                end
            end
            ST_SEARCH: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func            <= i_func;
            r_query.mac       <= i_mac_addr;
            r_query.vlan      <= i_vlan_id;
            r_query.port      <= i_port_num;
            r_query.mk_static <= i_make_static;
        end
        if (w_commit) begin
            r_hit        <= w_hit;
            r_out_port   <= w_hit ? w_last.port : '0;
            r_removed    <= w_cmd.del;
            r_table_full <= w_learn_ok && !w_last.found && !w_last.free_seen;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_out_port   = r_out_port;
    assign o_removed    = r_removed;
    assign o_table_full = r_table_full;

`ifndef SYNTHESIS
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.upd, w_cmd.ins, w_cmd.del}))
        else $error("more than one table update in a commit");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_hit, o_removed, o_table_full}))
        else $error("result word carries conflicting flags");

    a_miss_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_out_port == '0))
        else $error("port reported without a hit");

    a_accept_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SEARCH) && (r_cnt == '0))
        else $error("accepted word did not start a search");
`endif

endmodule

`default_nettype wire

>>> bench/mac_learning_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mac_learning_table_test
// Self-checking bench for the MAC learning table. Operations go in through
// the valid/stall input channel while a behavioral table model predicts each
// reply. Every reply taken from the output channel is compared field by field
// with the oldest prediction. Directed cases come first, then random traffic
// over a shared address pool, a fill of the whole table, traffic around the
// full state, more random traffic; random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module mac_learning_table_test;

    localparam int FUNC_W = mlt_pkg::FUNC_W;
    localparam int MAC_W  = mlt_pkg::MAC_W;
    localparam int VLAN_W = mlt_pkg::VLAN_W;
    localparam int PORT_W = mlt_pkg::PORT_W;

    localparam int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF;
    localparam int PORT_COUNT    = mlt_pkg::PORT_COUNT_DEF;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int          POOL_SIZE   = 48;
    localparam int unsigned ITEM_TARGET = 950;
    localparam int unsigned CYCLE_LIMIT = 1_600_000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MAC_W-1:0]  mac;
        logic [VLAN_W-1:0] vlan;
        logic [PORT_W-1:0] port;
        logic              mk_static;
    } t_table_op;

    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] port;
        logic              removed;
        logic              full;
    } t_table_reply;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic [FUNC_W-1:0]   i_func        = '0;
    logic [MAC_W-1:0]    i_mac_addr    = '0;
    logic [VLAN_W-1:0]   i_vlan_id     = '0;
    logic [PORT_W-1:0]   i_port_num    = '0;
    logic                i_make_static = 1'b0;
    logic                i_out_stall   = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_hit;
    logic [PORT_W-1:0]   o_out_port;
    logic                o_removed;
    logic                o_table_full;

    // Behavioral copy of the address table.
    logic                tbl_valid  [TABLE_ENTRIES];
    logic [MAC_W-1:0]    tbl_mac    [TABLE_ENTRIES];
    logic [VLAN_W-1:0]   tbl_vlan   [TABLE_ENTRIES];
    logic [PORT_W-1:0]   tbl_port   [TABLE_ENTRIES];
    logic                tbl_static [TABLE_ENTRIES];

    t_table_reply        pending_replies[$];
    logic [MAC_W-1:0]    mac_pool[POOL_SIZE];

    logic                idle_on     = 1'b0;
    int unsigned         out_hold    = 0;
    int unsigned         cycle_count = 0;
    int unsigned         errors      = 0;
    int unsigned         sent_count  = 0;
    int unsigned         learns_sent, lookups_sent, removes_sent, other_sent;
    int unsigned         replies_checked, hits_seen, removals_seen, drops_seen;

    mac_learning_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_mac_addr    (i_mac_addr),
        .i_vlan_id     (i_vlan_id),
        .i_port_num    (i_port_num),
        .i_make_static (i_make_static),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_out_port    (o_out_port),
        .o_removed     (o_removed),
        .o_table_full  (o_table_full)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------------
    function automatic int find_slot(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_mac[i] == mac) return i;
        end
        return -1;
    endfunction

    function automatic int find_free_slot();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!tbl_valid[i]) return i;
        end
        return -1;
    endfunction

    task automatic apply_table_op(input t_table_op op);
        t_table_reply reply;
        int           slot;
        reply = '0;
        case (op.func)
            mlt_pkg::FUNC_LEARN: begin
                if (op.mac != mlt_pkg::MAC_BCAST && int'(op.port) < PORT_COUNT) begin
                    slot = find_slot(op.mac);
                    if (slot < 0) begin
                        slot = find_free_slot();
                        if (slot < 0) begin
                            reply.full = 1'b1;
                        end else begin
                            tbl_valid[slot]  = 1'b1;
                            tbl_mac[slot]    = op.mac;
                            tbl_static[slot] = 1'b0;
                        end
                    end
                    // Static entries are locked against any later learn.
                    if (slot >= 0 && !tbl_static[slot]) begin
                        tbl_port[slot]   = op.port;
                        tbl_vlan[slot]   = op.vlan;
                        tbl_static[slot] = op.mk_static;
                    end
                end
            end
            mlt_pkg::FUNC_LOOKUP: begin
                if (op.mac != mlt_pkg::MAC_BCAST) begin
                    slot = find_slot(op.mac);
                    if (slot >= 0 && tbl_vlan[slot] == op.vlan) begin
                        reply.hit  = 1'b1;
                        reply.port = tbl_port[slot];
                    end
                end
            end
            mlt_pkg::FUNC_REMOVE: begin
                slot = find_slot(op.mac);
                if (slot >= 0 && tbl_static[slot]) begin
                    tbl_valid[slot] = 1'b0;
                    reply.removed   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        pending_replies.push_back(reply);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_table_op make_op(input logic [FUNC_W-1:0] func,
                                          input logic [MAC_W-1:0]  mac,
                                          input logic [VLAN_W-1:0] vlan,
                                          input logic [PORT_W-1:0] port,
                                          input logic              mk_static);
        t_table_op op;
        op.func      = func;
        op.mac       = mac;
        op.vlan      = vlan;
        op.port      = port;
        op.mk_static = mk_static;
        return op;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    // An address that is neither stored nor broadcast.
    function automatic logic [MAC_W-1:0] fresh_mac();
        logic [MAC_W-1:0] mac;
        mac = random_mac();
        while (mac == mlt_pkg::MAC_BCAST || find_slot(mac) >= 0) mac = random_mac();
        return mac;
    endfunction

    function automatic logic [MAC_W-1:0] stored_mac();
        int unsigned idx;
        idx = $urandom_range(0, TABLE_ENTRIES - 1);
        if (tbl_valid[idx]) return tbl_mac[idx];
        return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [MAC_W-1:0] pick_mac();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)  return mlt_pkg::MAC_BCAST;
        if (roll < 14) return random_mac();
        if (roll < 40) return stored_mac();
        return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        if ($urandom_range(0, 9) == 0) return PORT_W'($urandom_range(PORT_COUNT, 63));
        return PORT_W'($urandom_range(0, PORT_COUNT - 1));
    endfunction

    // Lookup VLAN: usually the stored one so that hits are common.
    function automatic logic [VLAN_W-1:0] lookup_vlan(input logic [MAC_W-1:0] mac);
        int slot;
        slot = find_slot(mac);
        if (slot >= 0 && $urandom_range(0, 4) != 0) return tbl_vlan[slot];
        return VLAN_W'($urandom_range(0, 4095));
    endfunction

    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sends one word and leaves valid high when the next word follows at once.
    task automatic send_op(input t_table_op op);
        int unsigned gap;
        i_in_valid    <= 1'b1;
        i_func        <= op.func;
        i_mac_addr    <= op.mac;
        i_vlan_id     <= op.vlan;
        i_port_num    <= op.port;
        i_make_static <= op.mk_static;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_table_op(op);
        sent_count++;
        case (op.func)
            mlt_pkg::FUNC_LEARN:  learns_sent++;
            mlt_pkg::FUNC_LOOKUP: lookups_sent++;
            mlt_pkg::FUNC_REMOVE: removes_sent++;
            default:              other_sent++;
        endcase
        gap = (idle_on && $urandom_range(0, 1) == 1) ? gap_length() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall and reply checking
    // ------------------------------------------------------------------------
    task automatic check_reply();
        t_table_reply want;
        if (pending_replies.size() == 0) begin
            $error("unexpected reply: hit %0d out_port %0d removed %0d table_full %0d",
                   o_hit, o_out_port, o_removed, o_table_full);
            errors++;
        end else begin
            want = pending_replies.pop_front();
            if (o_hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, o_hit);
                errors++;
            end
            if (o_out_port !== want.port) begin
                $error("out_port: expected %0d, actual %0d", want.port, o_out_port);
                errors++;
            end
            if (o_removed !== want.removed) begin
                $error("removed: expected %0d, actual %0d", want.removed, o_removed);
                errors++;
            end
            if (o_table_full !== want.full) begin
                $error("table_full: expected %0d, actual %0d", want.full, o_table_full);
                errors++;
            end
            replies_checked++;
            hits_seen     += 32'(want.hit);
            removals_seen += 32'(want.removed);
            drops_seen    += 32'(want.full);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_reply();
        if (out_hold != 0) begin
            out_hold    <= out_hold - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            out_hold    <= gap_length() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        logic [MAC_W-1:0] top_mac;
        top_mac = mlt_pkg::MAC_BCAST - 48'd1;
        idle_on = 1'b0;
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, '0, '0, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LEARN, '0, '0, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, '0, '0, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, '0, 12'hFFF, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LEARN, top_mac, 12'hFFF,
                        PORT_W'(PORT_COUNT - 1), 1'b1));
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, top_mac, 12'hFFF, '0, 1'b0));
        // A learn must not move a locked entry.
        send_op(make_op(mlt_pkg::FUNC_LEARN, top_mac, 12'h001, 6'd5, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, top_mac, 12'hFFF, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LEARN, mlt_pkg::MAC_BCAST, 12'h123, 6'd3, 1'b1));
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, mlt_pkg::MAC_BCAST, 12'h123, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_REMOVE, mlt_pkg::MAC_BCAST, '0, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LEARN, '0, '0, PORT_W'(PORT_COUNT), 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LEARN, '0, '0, 6'h3F, 1'b1));
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, '0, '0, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_REMOVE, '0, '0, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LEARN, '0, 12'd7, 6'd17, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, '0, 12'd7, '0, 1'b0));
        send_op(make_op(FUNC_UNUSED, mlt_pkg::MAC_BCAST, 12'hFFF, 6'h3F, 1'b1));
        send_op(make_op(mlt_pkg::FUNC_REMOVE, top_mac, '0, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LOOKUP, top_mac, 12'hFFF, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_REMOVE, 48'h0000_5E00_0101, '0, '0, 1'b0));
        send_op(make_op(mlt_pkg::FUNC_LEARN, '0, 12'd7, 6'd9, 1'b1));
        send_op(make_op(mlt_pkg::FUNC_REMOVE, '0, '0, '0, 1'b0));
        drain_replies();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        t_table_op   op;
        int unsigned n;
        int unsigned roll;
        for (n = 0; n < count; n++) begin
            // Each stretch of 60 words runs with or without idling, picked at random.
            if (n % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
            roll         = $urandom_range(0, 99);
            op.mac       = pick_mac();
            op.vlan      = VLAN_W'($urandom_range(0, 4095));
            op.port      = pick_port();
            op.mk_static = ($urandom_range(0, 3) == 0);
            if (roll < 40) begin
                op.func = mlt_pkg::FUNC_LEARN;
            end else if (roll < 80) begin
                op.func = mlt_pkg::FUNC_LOOKUP;
                op.vlan = lookup_vlan(op.mac);
            end else if (roll < 94) begin
                op.func = mlt_pkg::FUNC_REMOVE;
            end else begin
                op.func = FUNC_UNUSED;
            end
            send_op(op);
            if ($urandom_range(0, 99) == 0) drain_replies();
        end
        drain_replies();
    endtask

    task automatic test_table_full();
        t_table_op   op;
        int unsigned n;
        int unsigned roll;
        idle_on = 1'b0;
        while (find_free_slot() >= 0) begin
            send_op(make_op(mlt_pkg::FUNC_LEARN, fresh_mac(),
                            VLAN_W'($urandom_range(0, 4095)),
                            PORT_W'($urandom_range(0, PORT_COUNT - 1)),
                            1'($urandom_range(0, 1))));
        end
        idle_on = 1'b1;
        for (n = 0; n < 100; n++) begin
            roll         = $urandom_range(0, 99);
            op.vlan      = VLAN_W'($urandom_range(0, 4095));
            op.port      = PORT_W'($urandom_range(0, PORT_COUNT - 1));
            op.mk_static = 1'($urandom_range(0, 1));
            if (roll < 30) begin
                op.func = mlt_pkg::FUNC_LEARN;
                op.mac  = fresh_mac();
            end else if (roll < 50) begin
                op.func = mlt_pkg::FUNC_LEARN;
                op.mac  = stored_mac();
            end else if (roll < 75) begin
                op.func = mlt_pkg::FUNC_LOOKUP;
                op.mac  = stored_mac();
                op.vlan = lookup_vlan(op.mac);
            end else if (roll < 90) begin
                op.func = mlt_pkg::FUNC_REMOVE;
                op.mac  = stored_mac();
            end else begin
                op.func = mlt_pkg::FUNC_LOOKUP;
                op.mac  = fresh_mac();
            end
            send_op(op);
        end
        drain_replies();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_mac[i]    = '0;
            tbl_vlan[i]   = '0;
            tbl_port[i]   = '0;
            tbl_static[i] = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = random_mac();
        mac_pool[0] = '0;
        mac_pool[1] = mlt_pkg::MAC_BCAST - 48'd1;
        mac_pool[2] = ~mac_pool[3];
        learns_sent = 0; lookups_sent = 0; removes_sent = 0; other_sent = 0;
        replies_checked = 0; hits_seen = 0; removals_seen = 0; drops_seen = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(300);
        test_table_full();
        test_random_traffic(sent_count < ITEM_TARGET ? ITEM_TARGET - sent_count : 50);

        i_in_valid <= 1'b0;
        idle_on    = 1'b0;
        repeat (TABLE_ENTRIES + 16) @(posedge i_clk);

        $display("tb: %0d words sent (%0d learn, %0d lookup, %0d remove, %0d unused code)",
                 sent_count, learns_sent, lookups_sent, removes_sent, other_sent);
        $display("tb: %0d replies checked: %0d hits, %0d removals, %0d learns dropped on full",
                 replies_checked, hits_seen, removals_seen, drops_seen);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
sv/mlt_pkg.sv
sv/mlt_cell.sv
sv/mac_learning_table.sv
bench/mac_learning_table_test.sv
